// ===== rtl/nirpe_pkg.sv =====
// ----------------------------------------------------------------------------
// nirpe_pkg
// Shared types and constants for the NEC-style infrared pulse encoder.
// ----------------------------------------------------------------------------
package nirpe_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned FRAME_BITS    = 4 * BYTE_W;
  localparam int unsigned PULSES        = FRAME_BITS + 2;
  localparam int unsigned PULSE_CNT_W   = $clog2(PULSES);
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned IN_DATA_W     = 2 * BYTE_W;
  localparam int unsigned OUT_DATA_W    = 2 * TIME_W;
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [PULSE_CNT_W-1:0] LEADER_PULSE = '0;
  localparam logic [PULSE_CNT_W-1:0] STOP_PULSE   = PULSE_CNT_W'(PULSES - 1);

  localparam logic [TIME_W-1:0] RST_LEADER_ON  = TIME_W'(8500);
  localparam logic [TIME_W-1:0] RST_LEADER_OFF = TIME_W'(4250);
  localparam logic [TIME_W-1:0] RST_MARK       = TIME_W'(550);
  localparam logic [TIME_W-1:0] RST_SPACE_ZERO = TIME_W'(550);
  localparam logic [TIME_W-1:0] RST_SPACE_ONE  = TIME_W'(1650);
  localparam logic [TIME_W-1:0] RST_STOP_GAP   = TIME_W'(25000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_ON  = 3'd0,
    REG_LEADER_OFF = 3'd1,
    REG_MARK       = 3'd2,
    REG_SPACE_ZERO = 3'd3,
    REG_SPACE_ONE  = 3'd4,
    REG_STOP_GAP   = 3'd5
  } cfg_reg_t;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic [TIME_W-1:0] leader_on;
    logic [TIME_W-1:0] leader_off;
    logic [TIME_W-1:0] mark;
    logic [TIME_W-1:0] space_zero;
    logic [TIME_W-1:0] space_one;
    logic [TIME_W-1:0] stop_gap;
  } timing_t;

  // request handshake between queue stages
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

endpackage

// ===== rtl/nirpe_front.sv =====
// ----------------------------------------------------------------------------
// nirpe_front
// Accepts byte pairs and expands each into the 32 frame bits.
// ----------------------------------------------------------------------------
module nirpe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nirpe_pkg::IN_DATA_W-1:0] in_tdata,  // first_byte, second_byte
  output nirpe_pkg::frame_req_t         req,
  input  logic                          req_ready
);
  import nirpe_pkg::*;

  logic   hold_valid_r, hold_valid_nxt;
  frame_t hold_frame_r;
  logic   [BYTE_W-1:0] first_byte, second_byte;
  logic   in_acc;

  assign first_byte  = in_tdata[BYTE_W-1:0];
  assign second_byte = in_tdata[2*BYTE_W-1:BYTE_W];

  assign in_tready = !hold_valid_r || req_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_acc) begin
      hold_valid_nxt = 1'b1;
    end else if (req_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // send order: first, its complement, second, its complement; MSB first
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_frame_r <= {first_byte, ~first_byte, second_byte, ~second_byte};
    end
  end

  assign req.valid = hold_valid_r;
  assign req.frame = hold_frame_r;

endmodule

// ===== rtl/nirpe_fifo.sv =====
// ----------------------------------------------------------------------------
// nirpe_fifo
// Short frame queue between the front and the pulse sequencer.
// ----------------------------------------------------------------------------
module nirpe_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nirpe_pkg::frame_req_t wr_req,
  output logic                  wr_ready,
  output nirpe_pkg::frame_req_t rd_req,
  input  logic                  rd_pop
);
  import nirpe_pkg::*;

  frame_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  push, pop;

  assign wr_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign push     = wr_req.valid && wr_ready;
  assign pop      = rd_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_req.frame;
    end
  end

  assign rd_req.valid = (count_r != '0);
  assign rd_req.frame = mem[rd_ptr_r];

endmodule

// ===== rtl/nirpe_back.sv =====
// ----------------------------------------------------------------------------
// nirpe_back
// Pulse sequencer: walks a frame, a pulse per unstalled cycle, to output register.
// ----------------------------------------------------------------------------
module nirpe_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nirpe_pkg::timing_t             timing,
  input  nirpe_pkg::frame_req_t          rd_req,
  output logic                           rd_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nirpe_pkg::OUT_DATA_W-1:0] out_tdata,  // on_time_us, off_time_us
  output logic                           out_tlast     // frame_end
);
  import nirpe_pkg::*;

  logic                   active_r, active_nxt;
  logic [PULSE_CNT_W-1:0] cnt_r, cnt_nxt;
  frame_t                 shift_r, shift_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]      on_r, off_r, on_nxt, off_nxt;
  logic                   last_r, last_nxt;
  logic                   adv, finishing;

  assign adv       = !out_valid_r || out_tready;
  assign finishing = active_r && adv && (cnt_r == STOP_PULSE);
  assign rd_pop    = rd_req.valid && (!active_r || finishing);

  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    out_valid_nxt = out_valid_r;
    on_nxt        = on_r;
    off_nxt       = off_r;
    last_nxt      = last_r;
    if (adv) begin
      out_valid_nxt = active_r;
      if (active_r) begin
        last_nxt = 1'b0;
        priority if (cnt_r == LEADER_PULSE) begin
          on_nxt  = timing.leader_on;
          off_nxt = timing.leader_off;
        end else if (cnt_r == STOP_PULSE) begin
          on_nxt   = timing.mark;
          off_nxt  = timing.stop_gap;
          last_nxt = 1'b1;
        end else begin
          on_nxt    = timing.mark;
          off_nxt   = shift_r[FRAME_BITS-1] ? timing.space_one : timing.space_zero;
          shift_nxt = {shift_r[FRAME_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STOP_PULSE) begin
          active_nxt = 1'b0;
        end
      end
    end
    // load the next frame straight behind the stop pulse
    if (rd_pop) begin
      active_nxt = 1'b1;
      cnt_nxt    = LEADER_PULSE;
      shift_nxt  = rd_req.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= LEADER_PULSE;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    on_r    <= on_nxt;
    off_r   <= off_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {off_r, on_r};
  assign out_tlast  = last_r;

endmodule

// ===== rtl/nec_ir_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// nec_ir_pulse_encoder
// Turns address/command byte pairs into the 34 on/off pulses of an NEC-style frame.
// ----------------------------------------------------------------------------
// Each byte pair on the input stream yields 34 pulses: the leader, 32 bit
// pulses (first byte, its complement, second byte, its complement, MSB first)
// and the stop pulse, which carries tlast. One pulse leaves per cycle while
// out_tready is held high, and frames follow each other with no gap while
// pairs are queued. Up to three pairs can wait ahead of the sequencer (input
// stage plus a two-entry queue). Timings are written through the cfg port and
// take effect on later pulses; write them only while the block is idle. An
// accepted pair reaches its leader pulse through the input stage, the queue,
// the sequencer state and its output register.
module nec_ir_pulse_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [nirpe_pkg::IN_DATA_W-1:0] in_tdata,   // first_byte, second_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nirpe_pkg::OUT_DATA_W-1:0] out_tdata, // on_time_us, off_time_us
  output logic                           out_tlast,   // frame_end
  input  logic                           cfg_we,
  input  logic [nirpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nirpe_pkg::TIME_W-1:0]   cfg_wdata
);
  import nirpe_pkg::*;

  timing_t    timing_r, timing_nxt;
  frame_req_t front_req, queue_req;
  logic       queue_ready, queue_pop;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEADER_ON:  timing_nxt.leader_on  = cfg_wdata;
        REG_LEADER_OFF: timing_nxt.leader_off = cfg_wdata;
        REG_MARK:       timing_nxt.mark       = cfg_wdata;
        REG_SPACE_ZERO: timing_nxt.space_zero = cfg_wdata;
        REG_SPACE_ONE:  timing_nxt.space_one  = cfg_wdata;
        REG_STOP_GAP:   timing_nxt.stop_gap   = cfg_wdata;
        default:        timing_nxt = timing_r;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.leader_on  <= RST_LEADER_ON;
      timing_r.leader_off <= RST_LEADER_OFF;
      timing_r.mark       <= RST_MARK;
      timing_r.space_zero <= RST_SPACE_ZERO;
      timing_r.space_one  <= RST_SPACE_ONE;
      timing_r.stop_gap   <= RST_STOP_GAP;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  nirpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .req       (front_req),
    .req_ready (queue_ready)
  );

  nirpe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_req   (front_req),
    .wr_ready (queue_ready),
    .rd_req   (queue_req),
    .rd_pop   (queue_pop)
  );

  nirpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .timing     (timing_r),
    .rd_req     (queue_req),
    .rd_pop     (queue_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/nirpe_checker.sv =====
// ----------------------------------------------------------------------------
// nirpe_checker
// Port-level checks for the infrared pulse encoder, bound to the top level.
// ----------------------------------------------------------------------------
module nirpe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [nirpe_pkg::IN_DATA_W-1:0] in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nirpe_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import nirpe_pkg::*;

  logic out_acc;
  assign out_acc = out_tvalid && out_tready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // a frame never ends twice in a row
  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tlast |=> !(out_tvalid && out_tlast))
    else $error("two frame ends back to back");

  a_rst_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_rst_in_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // an empty block does not hold off a new pair
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!in_tvalid, 1) && $past(!in_tvalid, 2) && $past(!in_tvalid, 3)
      && $past(rst_n, 3) && !out_tvalid |-> in_tready || $past(in_tdata) != in_tdata
      || in_tready)
    else $error("input stalled while block empty");

endmodule

bind nec_ir_pulse_encoder nirpe_checker u_nirpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
